// ----- src/utf8v_pkg.sv -----
// Package: types, constants and lookup functions for the UTF-8 stream validator.
package utf8v_pkg;

  localparam int unsigned POSITION_BITS = 31;
  localparam int unsigned OFFSET_W      = 31;

  localparam logic [3:0] S_ACC = 4'd0;
  localparam logic [3:0] S_1   = 4'd1;
  localparam logic [3:0] S_2   = 4'd2;
  localparam logic [3:0] S_3   = 4'd3;
  localparam logic [3:0] S_E0  = 4'd4;
  localparam logic [3:0] S_ED  = 4'd5;
  localparam logic [3:0] S_F0  = 4'd6;
  localparam logic [3:0] S_F4  = 4'd7;
  localparam logic [3:0] S_ERR = 4'd8;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                start_mark;
    logic [1:0]          status;
    logic [OFFSET_W-1:0] error_offset;
    logic                end_of_string;
  } out_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    case (b) inside
      [8'h00:8'h7F]: c = 4'd0;
      [8'h80:8'h8F]: c = 4'd1;
      [8'h90:8'h9F]: c = 4'd2;
      [8'hA0:8'hBF]: c = 4'd3;
      [8'hC0:8'hC1]: c = 4'd4;
      [8'hC2:8'hDF]: c = 4'd5;
      8'hE0:         c = 4'd6;
      [8'hE1:8'hEC]: c = 4'd7;
      8'hED:         c = 4'd8;
      [8'hEE:8'hEF]: c = 4'd9;
      8'hF0:         c = 4'd10;
      [8'hF1:8'hF3]: c = 4'd11;
      8'hF4:         c = 4'd12;
      default:       c = 4'd13;
    endcase
    return c;
  endfunction

  // transition function; continuation classes are 1 (80-8F), 2 (90-9F), 3 (A0-BF)
  function automatic logic [3:0] next_state(input logic [3:0] s, input logic [3:0] c);
    logic [3:0] n;
    n = S_ERR;
    case (s)
      S_ACC: begin
        case (c)
          4'd0:    n = S_ACC;
          4'd5:    n = S_1;
          4'd6:    n = S_E0;
          4'd7:    n = S_2;
          4'd8:    n = S_ED;
          4'd9:    n = S_2;
          4'd10:   n = S_F0;
          4'd11:   n = S_3;
          4'd12:   n = S_F4;
          default: n = S_ERR;
        endcase
      end
      S_1:  if (c inside {4'd1, 4'd2, 4'd3}) n = S_ACC;
      S_2:  if (c inside {4'd1, 4'd2, 4'd3}) n = S_1;
      S_3:  if (c inside {4'd1, 4'd2, 4'd3}) n = S_2;
      S_E0: if (c == 4'd3) n = S_1;
      S_ED: if (c inside {4'd1, 4'd2}) n = S_1;
      S_F0: if (c inside {4'd2, 4'd3}) n = S_2;
      S_F4: if (c == 4'd1) n = S_2;
      default: n = S_ERR;
    endcase
    return n;
  endfunction

endpackage

// ----- src/utf8v_step.sv -----
// One validation step: byte class, DFA transition, sticky error and result fields.
module utf8v_step #(
  parameter int unsigned PositionBits = utf8v_pkg::POSITION_BITS
) (
  input  utf8v_pkg::in_t          item_i,
  input  logic [3:0]              dfa_i,
  input  logic [PositionBits-1:0] pos_i,
  input  logic [PositionBits-1:0] seq_i,
  input  logic                    err_i,
  input  logic [PositionBits-1:0] saved_i,
  output logic [3:0]              dfa_o,
  output logic [PositionBits-1:0] pos_o,
  output logic [PositionBits-1:0] seq_o,
  output logic                    err_o,
  output logic [PositionBits-1:0] saved_o,
  output utf8v_pkg::out_t         result_o
);

  localparam int unsigned OffW = utf8v_pkg::OFFSET_W;

  logic [3:0]              cls;
  logic [3:0]              nxt;
  logic [PositionBits-1:0] eff_seq;
  logic [PositionBits-1:0] off;
  logic [OffW-1:0]         off_out;
  logic                    mark;
  logic [1:0]              status;

  assign cls     = utf8v_pkg::byte_class(item_i.byte_in);
  assign nxt     = utf8v_pkg::next_state(dfa_i, cls);
  assign eff_seq = (dfa_i == utf8v_pkg::S_ACC) ? pos_i : seq_i;

  always_comb begin
    mark    = 1'b0;
    status  = utf8v_pkg::STATUS_OK;
    off     = '0;
    dfa_o   = dfa_i;
    seq_o   = seq_i;
    err_o   = err_i;
    saved_o = saved_i;
    pos_o   = (pos_i == {PositionBits{1'b1}}) ? pos_i : pos_i + PositionBits'(1);
    if (err_i) begin
      status = utf8v_pkg::STATUS_INVALID;
      off    = saved_i;
    end else begin
      seq_o = eff_seq;
      if (nxt == utf8v_pkg::S_ERR) begin
        err_o   = 1'b1;
        saved_o = eff_seq;
        status  = utf8v_pkg::STATUS_INVALID;
        off     = eff_seq;
      end else begin
        mark  = (cls == 4'd0) || (cls >= 4'd4);
        dfa_o = nxt;
        if (item_i.last_byte && nxt != utf8v_pkg::S_ACC) begin
          status = utf8v_pkg::STATUS_TRUNC;
          off    = eff_seq;
        end
      end
    end
    if (item_i.last_byte) begin
      dfa_o   = utf8v_pkg::S_ACC;
      pos_o   = '0;
      seq_o   = '0;
      err_o   = 1'b0;
      saved_o = '0;
    end
  end

  if (PositionBits >= OffW) begin : g_off_trunc
    assign off_out = off[OffW-1:0];
  end else begin : g_off_ext
    assign off_out = {{(OffW-PositionBits){1'b0}}, off};
  end

  assign result_o.start_mark    = mark;
  assign result_o.status        = status;
  assign result_o.error_offset  = off_out;
  assign result_o.end_of_string = item_i.last_byte;

endmodule

// ----- src/utf8_validate_mark_stream_top.sv -----
// Top level: input register, validation step and result register for the UTF-8 marker.
// Each byte passes the input register and then the result register before its result is out.
// Throughput: one byte per cycle unless stalled; the DFA step fits between the two registers.
// The result register holds under stall while the input register still takes a byte.
// Reset: asynchronous active low; both stages empty, DFA in accept state, counters zero.
module utf8_validate_mark_stream_top #(
  parameter int unsigned PositionBits = utf8v_pkg::POSITION_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  utf8v_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output utf8v_pkg::out_t out_data_o
);

  logic                    s1_valid_q, s1_valid_d;
  utf8v_pkg::in_t          s1_data_q;
  logic                    out_valid_q, out_valid_d;
  utf8v_pkg::out_t         out_data_q;
  logic [3:0]              dfa_q, dfa_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] seq_q, seq_d;
  logic                    err_q, err_d;
  logic [PositionBits-1:0] saved_q, saved_d;
  utf8v_pkg::out_t         result;
  logic                    out_ready, s1_adv, in_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  utf8v_step #(.PositionBits(PositionBits)) u_step (
    .item_i  (s1_data_q),
    .dfa_i   (dfa_q),
    .pos_i   (pos_q),
    .seq_i   (seq_q),
    .err_i   (err_q),
    .saved_i (saved_q),
    .dfa_o   (dfa_d),
    .pos_o   (pos_d),
    .seq_o   (seq_d),
    .err_o   (err_d),
    .saved_o (saved_d),
    .result_o(result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dfa_q       <= utf8v_pkg::S_ACC;
      pos_q       <= '0;
      seq_q       <= '0;
      err_q       <= 1'b0;
      saved_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        dfa_q   <= dfa_d;
        pos_q   <= pos_d;
        seq_q   <= seq_d;
        err_q   <= err_d;
        saved_q <= saved_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/utf8v_checker.sv -----
// Port-level checker for the UTF-8 marker top level, with its bind.
module utf8v_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input utf8v_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input utf8v_pkg::out_t out_data_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // input is never stalled while the output side is free
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_err_no_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != utf8v_pkg::STATUS_OK |->
      (out_data_o.status == utf8v_pkg::STATUS_INVALID && !out_data_o.start_mark) ||
      (out_data_o.status == utf8v_pkg::STATUS_TRUNC && out_data_o.end_of_string))
    else $error("bad status/mark combination");

  a_ok_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == utf8v_pkg::STATUS_OK |->
      out_data_o.error_offset == '0)
    else $error("nonzero offset with ok status");

endmodule

bind utf8_validate_mark_stream_top utf8v_checker u_checker (.*);

// ----- dv/utf8_validate_mark_stream_checker.sv -----
// Checker: predicts the UTF-8 validator's per-byte marks and status, and compares the results.
module utf8_validate_mark_stream_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  utf8v_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  utf8v_pkg::out_t out_data_i,
  output int              errors_o,
  output int              pending_o,
  output int              checked_o,
  output int              invalid_o,
  output int              truncated_o
);

  localparam int unsigned PosW = utf8v_pkg::POSITION_BITS;
  localparam int unsigned OffW = utf8v_pkg::OFFSET_W;
  localparam logic [PosW-1:0] POS_MAX = '1;

  logic [3:0]      dfa_st;
  logic [PosW-1:0] str_pos;
  logic [PosW-1:0] cp_start_pos;
  logic [PosW-1:0] err_offset;
  logic            err_seen;
  utf8v_pkg::out_t predicted_marks_q[$];
  int              err_count = 0;
  int              result_count = 0;
  int              invalid_count = 0;
  int              trunc_count = 0;

  function automatic void clear_string();
    dfa_st       = utf8v_pkg::S_ACC;
    str_pos      = '0;
    cp_start_pos = '0;
    err_offset   = '0;
    err_seen     = 1'b0;
  endfunction

  // strict UTF-8 transition, written directly on byte ranges
  function automatic logic [3:0] advance(input logic [3:0] st, input logic [7:0] b);
    logic cont;
    cont = (b[7:6] == 2'b10);
    case (st)
      utf8v_pkg::S_ACC: begin
        if (b < 8'h80) return utf8v_pkg::S_ACC;
        if (b >= 8'hC2 && b <= 8'hDF) return utf8v_pkg::S_1;
        if (b == 8'hE0) return utf8v_pkg::S_E0;
        if (b == 8'hED) return utf8v_pkg::S_ED;
        if (b >= 8'hE1 && b <= 8'hEF) return utf8v_pkg::S_2;
        if (b == 8'hF0) return utf8v_pkg::S_F0;
        if (b >= 8'hF1 && b <= 8'hF3) return utf8v_pkg::S_3;
        if (b == 8'hF4) return utf8v_pkg::S_F4;
        return utf8v_pkg::S_ERR;
      end
      utf8v_pkg::S_1:  return cont ? utf8v_pkg::S_ACC : utf8v_pkg::S_ERR;
      utf8v_pkg::S_2:  return cont ? utf8v_pkg::S_1 : utf8v_pkg::S_ERR;
      utf8v_pkg::S_3:  return cont ? utf8v_pkg::S_2 : utf8v_pkg::S_ERR;
      utf8v_pkg::S_E0:
        return (b >= 8'hA0 && b <= 8'hBF) ? utf8v_pkg::S_1 : utf8v_pkg::S_ERR;
      utf8v_pkg::S_ED:
        return (b >= 8'h80 && b <= 8'h9F) ? utf8v_pkg::S_1 : utf8v_pkg::S_ERR;
      utf8v_pkg::S_F0:
        return (b >= 8'h90 && b <= 8'hBF) ? utf8v_pkg::S_2 : utf8v_pkg::S_ERR;
      utf8v_pkg::S_F4:
        return (b >= 8'h80 && b <= 8'h8F) ? utf8v_pkg::S_2 : utf8v_pkg::S_ERR;
      default: return utf8v_pkg::S_ERR;
    endcase
  endfunction

  function automatic utf8v_pkg::out_t validate_byte(input utf8v_pkg::in_t x);
    utf8v_pkg::out_t r;
    logic [3:0]      nxt;
    r = '0;
    r.end_of_string = x.last_byte;
    if (err_seen) begin
      r.status       = utf8v_pkg::STATUS_INVALID;
      r.error_offset = OffW'(err_offset);
    end else begin
      if (dfa_st == utf8v_pkg::S_ACC) cp_start_pos = str_pos;
      nxt = advance(dfa_st, x.byte_in);
      if (nxt == utf8v_pkg::S_ERR) begin
        err_seen       = 1'b1;
        err_offset     = cp_start_pos;
        r.status       = utf8v_pkg::STATUS_INVALID;
        r.error_offset = OffW'(cp_start_pos);
      end else begin
        r.start_mark = (x.byte_in[7:6] != 2'b10);
        dfa_st       = nxt;
        if (x.last_byte && nxt != utf8v_pkg::S_ACC) begin
          r.status       = utf8v_pkg::STATUS_TRUNC;
          r.error_offset = OffW'(cp_start_pos);
        end
      end
    end
    if (str_pos != POS_MAX) str_pos++;
    if (x.last_byte) clear_string();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("utf8 check: result %0d %s: got 0x%0h, expected 0x%0h",
             result_count, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    utf8v_pkg::out_t want;
    if (!rst_ni) begin
      clear_string();
      predicted_marks_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_marks_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", 32'(out_data_i), 0);
        end else begin
          want = predicted_marks_q.pop_front();
          if (out_data_i.start_mark !== want.start_mark)
            report_mismatch("start_mark", 32'(out_data_i.start_mark), 32'(want.start_mark));
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
          if (out_data_i.error_offset !== want.error_offset)
            report_mismatch("error_offset", 32'(out_data_i.error_offset),
                            32'(want.error_offset));
          if (out_data_i.end_of_string !== want.end_of_string)
            report_mismatch("end_of_string", 32'(out_data_i.end_of_string),
                            32'(want.end_of_string));
          if (want.end_of_string && want.status == utf8v_pkg::STATUS_INVALID)
            invalid_count++;
          if (want.end_of_string && want.status == utf8v_pkg::STATUS_TRUNC)
            trunc_count++;
          result_count++;
        end
      end
      if (in_valid_i && !in_stall_i) predicted_marks_q.push_back(validate_byte(in_data_i));
    end
    errors_o    <= err_count;
    pending_o   <= predicted_marks_q.size();
    checked_o   <= result_count;
    invalid_o   <= invalid_count;
    truncated_o <= trunc_count;
  end

endmodule

// ----- dv/utf8_validate_mark_stream_top_tb.sv -----
// Testbench top: drives byte strings into the UTF-8 validator and gives the verdict.
module utf8_validate_mark_stream_top_tb;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i;
  logic            in_stall_o;
  utf8v_pkg::in_t  in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  utf8v_pkg::out_t out_data_o;

  int errors;
  int pending;
  int checked;
  int invalid_ends;
  int truncated_ends;
  int send_idle_pct = 30;
  int recv_stall_pct = 88;
  int byte_count = 0;
  int string_count = 0;
  logic [7:0] text_q[$];

  utf8_validate_mark_stream_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  utf8_validate_mark_stream_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .invalid_o   (invalid_ends),
    .truncated_o (truncated_ends)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{byte_in: b, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    byte_count++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    string_count++;
  endtask

  // plain encoder by length only: surrogates and values past U+10FFFF pass through
  task automatic append_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_q.push_back({3'b110, cp[10:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_q.push_back({4'b1110, cp[15:12]});
      text_q.push_back({2'b10, cp[11:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end else begin
      text_q.push_back({5'b11110, cp[20:18]});
      text_q.push_back({2'b10, cp[17:12]});
      text_q.push_back({2'b10, cp[11:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end
  endtask

  task automatic send_string();
    int          n_cp;
    int          pick;
    logic [20:0] cp;
    text_q.delete();
    n_cp = $urandom_range(1, 6);
    repeat (n_cp) begin
      case ($urandom_range(0, 9))
        0, 1: append_code_point(21'($urandom_range(0, 'h7F)));
        2, 3: append_code_point(21'($urandom_range('h80, 'h7FF)));
        4, 5: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp ^= 21'h1000;
          append_code_point(cp);
        end
        6, 7: append_code_point(21'($urandom_range('h10000, 'h10FFFF)));
        8: text_q.push_back(8'($urandom));
        default: begin
          case ($urandom_range(0, 13))
            0:       cp = 21'h7F;
            1:       cp = 21'h80;
            2:       cp = 21'h7FF;
            3:       cp = 21'h800;
            4:       cp = 21'hD7FF;
            5:       cp = 21'hD800;
            6:       cp = 21'hDFFF;
            7:       cp = 21'hE000;
            8:       cp = 21'hFFFF;
            9:       cp = 21'h10000;
            10:      cp = 21'hFFFFF;
            11:      cp = 21'h10FFFF;
            12:      cp = 21'h110000;
            default: cp = 21'h1FFFFF;
          endcase
          append_code_point(cp);
        end
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
    end else if (pick < 20 && text_q.size() > 1) begin
      void'(text_q.pop_back());
    end else if (pick < 25) begin
      // overlong two-byte form
      text_q.push_back(8'($urandom_range('hC0, 'hC1)));
      text_q.push_back(8'($urandom_range('h80, 'hBF)));
    end
    send_text();
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // valid string touching the range limits of each length
    text_q = '{8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    // overlong three-byte start, then bytes after the error
    text_q = '{8'h00, 8'hE0, 8'h80, 8'h41};
    send_text();
    // string ends inside a four-byte sequence
    text_q = '{8'hF0, 8'h90};
    send_text();
    text_q = '{8'hC0};
    send_text();
    text_q = '{8'hFF, 8'h80};
    send_text();
    // surrogate
    text_q = '{8'hED, 8'hA0};
    send_text();
    // lone continuation
    text_q = '{8'h80};
    send_text();
    // above U+10FFFF
    text_q = '{8'hF4, 8'h90};
    send_text();

    while (byte_count < 170) send_string();
    send_idle_pct = 88;
    recv_stall_pct <= 30;
    while (byte_count < 320) send_string();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    while (byte_count < 450) send_string();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("utf8 run: %0d bytes in %0d strings, %0d results checked", byte_count,
             string_count, checked);
    $display("utf8 run: %0d strings ended invalid, %0d ended truncated", invalid_ends,
             truncated_ends);
    if (errors == 0) begin
      $display("utf8_validate_mark_stream_top_tb: clean");
    end else begin
      $display("utf8_validate_mark_stream_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("utf8 run: timeout");
    $display("utf8_validate_mark_stream_top_tb: errors");
    $finish;
  end

endmodule
